### src/msm_pkg.sv
// ----------------------------------------------------------------------------
// msm_pkg
// Shared types, constants and the character folding function of the
// multi-phrase sentence matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package msm_pkg;

  localparam int NODE_COUNT   = 8192;
  localparam int NODE_AW      = $clog2(NODE_COUNT);
  localparam int REPLAY_DEPTH = 64;
  localparam int RC_W         = $clog2(REPLAY_DEPTH + 1);
  localparam int RING_AW      = $clog2(REPLAY_DEPTH + 2);
  localparam int RING_DEPTH   = 1 << RING_AW;
  localparam int MAX_RESULTS  = 64;
  localparam int RES_CNT_W    = $clog2(MAX_RESULTS + 1);

  localparam logic       OP_WRITE = 1'b0;
  localparam logic       OP_SCAN  = 1'b1;

  localparam logic [1:0] EV_MATCH = 2'd0;
  localparam logic [1:0] EV_SENT  = 2'd1;
  localparam logic [1:0] EV_ACK   = 2'd2;

  localparam logic [7:0] NEG_CODE = 8'hFF;
  localparam logic [6:0] DOT_CHAR = 7'h2E;
  localparam logic [6:0] SP_CHAR  = 7'h20;
  localparam logic [7:0] NL_BYTE  = 8'h0A;

  typedef struct packed {
    logic [6:0]  ch;
    logic [7:0]  code;
    logic [12:0] child;
    logic [12:0] sib;
    logic [12:0] fail;
  } msm_node_t;

  localparam int NODE_W = $bits(msm_node_t);

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] m_start;
    logic [31:0] m_end;
    logic [31:0] line;
    logic        had;
    logic        last;
  } msm_result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_BYTE,
    ST_FOLD,
    ST_WALK,
    ST_OUT,
    ST_APPLY,
    ST_FAIL,
    ST_DONE
  } msm_state_t;

  function automatic logic [6:0] fold_char(input logic [7:0] b);
    logic [6:0] r;
    r = 7'd0;
    if (b[7]) begin
      r = 7'd0;
    end else if (b == NL_BYTE) begin
      r = SP_CHAR;
    end else if (b < 8'h20) begin
      r = 7'd0;
    end else if (b == 8'h21 || b == 8'h2E || b == 8'h3F) begin
      r = DOT_CHAR;
    end else if (b >= 8'h30 && b <= 8'h39) begin
      r = b[6:0];
    end else if (b >= 8'h41 && b <= 8'h5A) begin
      r = b[6:0] | 7'h20;
    end else if (b >= 8'h61 && b <= 8'h7A) begin
      r = b[6:0];
    end else begin
      r = SP_CHAR;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/msm_if.sv
// ----------------------------------------------------------------------------
// msm_in_if / msm_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface msm_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [12:0] node_index;
  logic [6:0]  node_char;
  logic [7:0]  node_output;
  logic [12:0] node_child;
  logic [12:0] node_sibling;
  logic [12:0] node_failure;
  logic [7:0]  text_byte;

  modport source (output valid, operation, node_index, node_char, node_output,
                  node_child, node_sibling, node_failure, text_byte,
                  input ready);
  modport sink (input valid, operation, node_index, node_char, node_output,
                node_child, node_sibling, node_failure, text_byte,
                output ready);
endinterface

interface msm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [31:0] match_start;
  logic [31:0] match_end;
  logic [31:0] line_number;
  logic        sentence_had_match;
  logic        last_of_run;

  modport source (output valid, event_kind, match_start, match_end, line_number,
                  sentence_had_match, last_of_run, input ready);
  modport sink (input valid, event_kind, match_start, match_end, line_number,
                sentence_had_match, last_of_run, output ready);
endinterface

`default_nettype wire

### src/msm_ram.sv
// ----------------------------------------------------------------------------
// msm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module msm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/multi_phrase_sentence_matcher_unit.sv
// ----------------------------------------------------------------------------
// multi_phrase_sentence_matcher_unit
// Phrase automaton scanner: loads nodes, scans text, reports matches and
// sentence ends.
// ----------------------------------------------------------------------------
// in_chan carries one item per handshake: a node write (operation 0) or a
// text byte (operation 1). out_chan carries result items; last_of_run marks
// the final result caused by one input item.
// A node write yields one acknowledge item. A text byte is read from the
// text ring, folded, walked along its sibling and failure links in the node
// RAM (one read per cycle, at least one) and applied; each byte replayed
// after an abandoned held match is walked again, and each abandoned hold
// passes through ST_FAIL.
// Results are staged one deep so the last of a run can be flagged; the
// block stalls in place when a new result meets a full pending register,
// a full output register and low out_chan.ready. A new item is taken only
// once the last result of the previous one has reached the output register.
// Reset clears the scan state, positions and line count (line 1); the node
// RAM and the text ring are not cleared and must be written before use.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_phrase_sentence_matcher_unit
  import msm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  msm_in_if.sink     in_chan,
  msm_out_if.source  out_chan
);

  msm_state_t               state_r, state_nxt;
  logic [NODE_AW-1:0]       cur_node_r, cur_node_nxt;
  logic                     held_valid_r, held_valid_nxt;
  logic [NODE_AW-1:0]       held_node_r, held_node_nxt;
  logic [31:0]              held_pos_r, held_pos_nxt;
  logic [31:0]              held_line_r, held_line_nxt;
  logic [31:0]              held_prev_line_r, held_prev_line_nxt;
  logic [RC_W-1:0]          rc_r, rc_nxt;
  logic [31:0]              stream_pos_r, stream_pos_nxt;
  logic [31:0]              line_r, line_nxt;
  logic                     sent_hit_r, sent_hit_nxt;
  logic [31:0]              p_r, p_nxt;
  logic [31:0]              end_r, end_nxt;
  logic [7:0]               byte_r, byte_nxt;
  logic [6:0]               f_r, f_nxt;
  logic [NODE_AW-1:0]       walk_node_r, walk_node_nxt;
  logic [NODE_AW-1:0]       c_r, c_nxt;
  logic [NODE_AW-1:0]       cfail_r, cfail_nxt;
  logic                     first_r, first_nxt;
  logic [NODE_AW-1:0]       scnt_r, scnt_nxt;
  logic [NODE_AW-1:0]       fcnt_r, fcnt_nxt;
  logic [7:0]               nx_out_r, nx_out_nxt;
  logic                     rescan_valid_r, rescan_valid_nxt;
  logic [31:0]              rescan_at_r, rescan_at_nxt;
  logic [RES_CNT_W-1:0]     res_cnt_r, res_cnt_nxt;
  logic                     pend_valid_r, pend_valid_nxt;
  msm_result_t              pend_r, pend_nxt;
  logic                     out_valid_r, out_valid_nxt;
  msm_result_t              out_r, out_nxt;

  msm_node_t                nd;
  msm_node_t                node_wdata;
  logic [7:0]               ring_rdata;
  logic                     in_fire;
  logic                     can_push;
  logic                     emit_req;
  msm_result_t              emit_res;
  logic                     stall;
  logic                     is_nl;
  logic                     hit;
  logic [NODE_AW-1:0]       cf;
  logic [31:0]              p_inc;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign can_push = !out_valid_r || out_chan.ready;
  assign is_nl    = (byte_r == NL_BYTE);
  assign hit      = (f_r != 7'd0) && (nd.ch == f_r);
  assign cf       = first_r ? nd.fail : cfail_r;
  assign p_inc    = p_r + 32'd1;

  assign node_wdata.ch    = in_chan.node_char;
  assign node_wdata.code  = in_chan.node_output;
  assign node_wdata.child = in_chan.node_child;
  assign node_wdata.sib   = in_chan.node_sibling;
  assign node_wdata.fail  = in_chan.node_failure;

  msm_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk   (clk),
    .we    (in_fire && (in_chan.operation == OP_WRITE)),
    .waddr (in_chan.node_index),
    .wdata (node_wdata),
    .raddr (walk_node_nxt),
    .rdata (nd)
  );

  msm_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring_ram (
    .clk   (clk),
    .we    (in_fire && (in_chan.operation == OP_SCAN)),
    .waddr (stream_pos_r[RING_AW-1:0]),
    .wdata (in_chan.text_byte),
    .raddr (p_nxt[RING_AW-1:0]),
    .rdata (ring_rdata)
  );

  always_comb begin
    emit_req = 1'b0;
    emit_res = '0;
    if (state_r == ST_APPLY && !held_valid_r && nx_out_r == 8'd0 && f_r == DOT_CHAR) begin
      emit_req         = 1'b1;
      emit_res.kind    = EV_SENT;
      emit_res.m_end   = p_r;
      emit_res.line    = line_r;
      emit_res.had     = sent_hit_r;
    end else if (state_r == ST_FAIL && nd.code != NEG_CODE) begin
      emit_req         = 1'b1;
      emit_res.kind    = EV_MATCH;
      emit_res.m_start = held_pos_r - {24'd0, nd.code};
      emit_res.m_end   = held_pos_r;
      emit_res.line    = held_line_r;
    end
  end

  assign stall = emit_req && (res_cnt_r != RES_CNT_W'(MAX_RESULTS)) &&
                 pend_valid_r && !can_push;

  always_comb begin
    state_nxt          = state_r;
    cur_node_nxt       = cur_node_r;
    held_valid_nxt     = held_valid_r;
    held_node_nxt      = held_node_r;
    held_pos_nxt       = held_pos_r;
    held_line_nxt      = held_line_r;
    held_prev_line_nxt = held_prev_line_r;
    rc_nxt             = rc_r;
    stream_pos_nxt     = stream_pos_r;
    line_nxt           = line_r;
    sent_hit_nxt       = sent_hit_r;
    p_nxt              = p_r;
    end_nxt            = end_r;
    byte_nxt           = byte_r;
    f_nxt              = f_r;
    walk_node_nxt      = walk_node_r;
    c_nxt              = c_r;
    cfail_nxt          = cfail_r;
    first_nxt          = first_r;
    scnt_nxt           = scnt_r;
    fcnt_nxt           = fcnt_r;
    nx_out_nxt         = nx_out_r;
    rescan_valid_nxt   = rescan_valid_r;
    rescan_at_nxt      = rescan_at_r;
    res_cnt_nxt        = res_cnt_r;
    pend_valid_nxt     = pend_valid_r;
    pend_nxt           = pend_r;
    out_valid_nxt      = out_valid_r && !out_chan.ready;
    out_nxt            = out_r;

    if (!stall) begin
      if (emit_req && res_cnt_r != RES_CNT_W'(MAX_RESULTS)) begin
        if (pend_valid_r) begin
          out_valid_nxt = 1'b1;
          out_nxt       = pend_r;
          out_nxt.last  = 1'b0;
        end
        pend_valid_nxt = 1'b1;
        pend_nxt       = emit_res;
        res_cnt_nxt    = res_cnt_r + RES_CNT_W'(1);
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_chan.operation == OP_WRITE) begin
              pend_valid_nxt = 1'b1;
              pend_nxt       = '0;
              pend_nxt.kind  = EV_ACK;
              state_nxt      = ST_DONE;
            end else begin
              p_nxt            = stream_pos_r;
              end_nxt          = stream_pos_r + 32'd1;
              stream_pos_nxt   = stream_pos_r + 32'd1;
              rescan_valid_nxt = 1'b0;
              res_cnt_nxt      = '0;
              state_nxt        = ST_RD_BYTE;
            end
          end
        end

        ST_RD_BYTE: begin
          state_nxt = ST_FOLD;
        end

        ST_FOLD: begin
          byte_nxt      = ring_rdata;
          f_nxt         = fold_char(ring_rdata);
          walk_node_nxt = cur_node_r;
          c_nxt         = cur_node_r;
          first_nxt     = 1'b1;
          scnt_nxt      = '0;
          fcnt_nxt      = '0;
          state_nxt     = ST_WALK;
        end

        ST_WALK: begin
          first_nxt = 1'b0;
          if (first_r) begin
            cfail_nxt = nd.fail;
          end
          if (hit) begin
            walk_node_nxt = nd.child;
            state_nxt     = ST_OUT;
          end else if (nd.sib != '0 && scnt_r != NODE_AW'(NODE_COUNT - 1)) begin
            walk_node_nxt = nd.sib;
            scnt_nxt      = scnt_r + NODE_AW'(1);
          end else if (held_valid_r) begin
            walk_node_nxt = held_node_r;
            state_nxt     = ST_FAIL;
          end else if (c_r == '0) begin
            walk_node_nxt = '0;
            state_nxt     = ST_OUT;
          end else if (cf == '0) begin
            c_nxt         = '0;
            walk_node_nxt = '0;
            first_nxt     = 1'b1;
            scnt_nxt      = '0;
          end else if (fcnt_r == NODE_AW'(NODE_COUNT - 1)) begin
            walk_node_nxt = '0;
            state_nxt     = ST_OUT;
          end else begin
            fcnt_nxt      = fcnt_r + NODE_AW'(1);
            c_nxt         = cf;
            walk_node_nxt = cf;
            first_nxt     = 1'b1;
            scnt_nxt      = '0;
          end
        end

        ST_OUT: begin
          nx_out_nxt = nd.code;
          state_nxt  = ST_APPLY;
        end

        ST_APPLY: begin
          p_nxt     = p_inc;
          state_nxt = (p_inc == end_r) ? ST_DONE : ST_RD_BYTE;
          if (nx_out_r != 8'd0 &&
              !(!held_valid_r && nx_out_r == NEG_CODE && rescan_valid_r &&
                p_r == rescan_at_r)) begin
            held_valid_nxt     = 1'b1;
            held_node_nxt      = walk_node_r;
            held_pos_nxt       = p_r;
            held_prev_line_nxt = line_r;
            line_nxt           = line_r + {31'd0, is_nl};
            held_line_nxt      = line_r + {31'd0, is_nl};
            rc_nxt             = '0;
            cur_node_nxt       = walk_node_r;
          end else if (held_valid_r) begin
            if (rc_r < RC_W'(REPLAY_DEPTH)) begin
              rc_nxt       = rc_r + RC_W'(1);
              line_nxt     = line_r + {31'd0, is_nl};
              cur_node_nxt = walk_node_r;
            end else begin
              p_nxt         = p_r;
              walk_node_nxt = held_node_r;
              state_nxt     = ST_FAIL;
            end
          end else if (nx_out_r != 8'd0) begin
            line_nxt     = line_r + {31'd0, is_nl};
            cur_node_nxt = '0;
          end else begin
            line_nxt     = line_r + {31'd0, is_nl};
            cur_node_nxt = walk_node_r;
            if (f_r == DOT_CHAR) begin
              sent_hit_nxt = 1'b0;
              cur_node_nxt = '0;
            end
          end
        end

        ST_FAIL: begin
          held_valid_nxt = 1'b0;
          cur_node_nxt   = '0;
          rc_nxt         = '0;
          if (nd.code == NEG_CODE) begin
            p_nxt            = held_pos_r;
            line_nxt         = held_prev_line_r;
            rescan_valid_nxt = 1'b1;
            rescan_at_nxt    = held_pos_r;
          end else begin
            sent_hit_nxt = 1'b1;
            p_nxt        = held_pos_r + 32'd1;
            line_nxt     = held_line_r;
          end
          state_nxt = ST_RD_BYTE;
        end

        ST_DONE: begin
          if (!pend_valid_r) begin
            state_nxt = ST_IDLE;
          end else if (can_push) begin
            out_valid_nxt  = 1'b1;
            out_nxt        = pend_r;
            out_nxt.last   = 1'b1;
            pend_valid_nxt = 1'b0;
            state_nxt      = ST_IDLE;
          end
        end

        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      cur_node_r       <= '0;
      held_valid_r     <= 1'b0;
      held_node_r      <= '0;
      held_pos_r       <= '0;
      held_line_r      <= 32'd1;
      held_prev_line_r <= 32'd1;
      rc_r             <= '0;
      stream_pos_r     <= '0;
      line_r           <= 32'd1;
      sent_hit_r       <= 1'b0;
      rescan_valid_r   <= 1'b0;
      res_cnt_r        <= '0;
      pend_valid_r     <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      cur_node_r       <= cur_node_nxt;
      held_valid_r     <= held_valid_nxt;
      held_node_r      <= held_node_nxt;
      held_pos_r       <= held_pos_nxt;
      held_line_r      <= held_line_nxt;
      held_prev_line_r <= held_prev_line_nxt;
      rc_r             <= rc_nxt;
      stream_pos_r     <= stream_pos_nxt;
      line_r           <= line_nxt;
      sent_hit_r       <= sent_hit_nxt;
      rescan_valid_r   <= rescan_valid_nxt;
      res_cnt_r        <= res_cnt_nxt;
      pend_valid_r     <= pend_valid_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r         <= p_nxt;
    end_r       <= end_nxt;
    byte_r      <= byte_nxt;
    f_r         <= f_nxt;
    walk_node_r <= walk_node_nxt;
    c_r         <= c_nxt;
    cfail_r     <= cfail_nxt;
    first_r     <= first_nxt;
    scnt_r      <= scnt_nxt;
    fcnt_r      <= fcnt_nxt;
    nx_out_r    <= nx_out_nxt;
    rescan_at_r <= rescan_at_nxt;
    pend_r      <= pend_nxt;
    out_r       <= out_nxt;
  end

  assign in_chan.ready               = (state_r == ST_IDLE);
  assign out_chan.valid              = out_valid_r;
  assign out_chan.event_kind         = out_r.kind;
  assign out_chan.match_start        = out_r.m_start;
  assign out_chan.match_end          = out_r.m_end;
  assign out_chan.line_number        = out_r.line;
  assign out_chan.sentence_had_match = out_r.had;
  assign out_chan.last_of_run        = out_r.last;

endmodule

`default_nettype wire

### tb/sv/tb_multi_phrase_sentence_matcher_unit.sv
// ----------------------------------------------------------------------------
// tb_multi_phrase_sentence_matcher_unit
// Loads a random phrase automaton, scans directed and random text
// through the matcher under random input gaps and output stalls, and checks
// every result item against a cycle-free predictor kept in a scoreboard.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_multi_phrase_sentence_matcher_unit;
  import msm_pkg::*;

  localparam int POOL       = 32;
  localparam int TOP_NODE   = NODE_COUNT - 1;
  localparam int QUEUE_CAP  = REPLAY_DEPTH + 2;
  localparam int CYCLE_MAX  = 2000000;
  localparam int HOLD_LEN   = 400;
  localparam int DRAIN_WAIT = 200;

  typedef struct {
    logic        op;
    logic [12:0] idx;
    msm_node_t   nd;
    logic [7:0]  text;
  } scan_item_t;

  class match_scoreboard;
    msm_node_t   nodes [NODE_COUNT];
    logic [6:0]  fold_map [128];
    logic [12:0] cur_node, held_node;
    bit          held_valid, sent_hit;
    logic [31:0] held_pos, held_line, held_prev_line, stream_pos, line_cnt;
    logic [7:0]  held_byte;
    logic [7:0]  replay [$];
    msm_result_t run [$];
    msm_result_t pending [$];
    int          errors;

    function new();
      int b;
      for (b = 0; b < 128; b++) begin
        if (b == 10) fold_map[b] = SP_CHAR;
        else if (b < 32) fold_map[b] = 7'd0;
        else if (b == 33 || b == 46 || b == 63) fold_map[b] = DOT_CHAR;
        else if (b >= 48 && b <= 57) fold_map[b] = 7'(b);
        else if (b >= 65 && b <= 90) fold_map[b] = 7'(b + 32);
        else if (b >= 97 && b <= 122) fold_map[b] = 7'(b);
        else fold_map[b] = SP_CHAR;
      end
      cur_node = 0; held_node = 0; held_valid = 0; sent_hit = 0;
      held_pos = 0; held_line = 1; held_prev_line = 1; held_byte = 0;
      stream_pos = 0; line_cnt = 1; errors = 0;
    endfunction

    function logic [6:0] fold_byte(logic [7:0] b);
      return b[7] ? 7'd0 : fold_map[b[6:0]];
    endfunction

    function bit sib_hit(logic [12:0] n, logic [6:0] f, output logic [12:0] nx);
      int i;
      nx = 0;
      for (i = 0; i < NODE_COUNT; i++) begin
        if (f != 0 && nodes[n].ch == f) begin
          nx = nodes[n].child;
          return 1;
        end
        if (nodes[n].sib == 0) return 0;
        n = nodes[n].sib;
      end
      return 0;
    endfunction

    function logic [12:0] transition(logic [12:0] c, logic [6:0] f);
      logic [12:0] nx;
      int i;
      for (i = 0; i < NODE_COUNT; i++) begin
        if (sib_hit(c, f, nx)) return nx;
        if (c == 0) return 0;
        c = nodes[c].fail;
        if (c == 0) return sib_hit(0, f, nx) ? nx : 13'd0;
      end
      return 0;
    endfunction

    function void push_event(logic [1:0] k, logic [31:0] s, logic [31:0] e,
                             logic [31:0] ln, logic had);
      msm_result_t r;
      if (run.size() >= MAX_RESULTS) return;
      r.kind = k; r.m_start = s; r.m_end = e; r.line = ln; r.had = had; r.last = 0;
      run.push_back(r);
    endfunction

    function void hold_match(logic [12:0] n, logic [31:0] p, logic [7:0] b);
      held_valid = 1; held_node = n; held_pos = p; held_byte = b;
      held_prev_line = line_cnt;
      if (b == NL_BYTE) line_cnt++;
      held_line = line_cnt;
      replay.delete();
      cur_node = n;
    endfunction

    function void scan_text(logic [7:0] first);
      logic [7:0]  q [$];
      logic [7:0]  nq [$];
      logic [7:0]  b;
      logic [6:0]  f;
      logic [12:0] nx;
      logic [7:0]  code;
      logic [31:0] qpos, p, rescan_at;
      bit          ok, rescan_valid;
      int          qi, k;
      q.push_back(first);
      qi = 0; qpos = stream_pos; rescan_valid = 0; rescan_at = 0;
      stream_pos++;
      while (qi < q.size()) begin
        b = q[qi]; p = qpos + qi; f = fold_byte(b);
        if (held_valid) begin
          ok = sib_hit(cur_node, f, nx);
          if (ok && nodes[nx].code != 0) begin
            hold_match(nx, p, b);
            qi++;
            continue;
          end
          if (ok && replay.size() < REPLAY_DEPTH) begin
            replay.push_back(b);
            if (b == NL_BYTE) line_cnt++;
            cur_node = nx;
            qi++;
            continue;
          end
          code = nodes[held_node].code;
          held_valid = 0; cur_node = 0;
          nq.delete();
          if (code == NEG_CODE) begin
            nq.push_back(held_byte);
            qpos = held_pos; line_cnt = held_prev_line;
            rescan_valid = 1; rescan_at = held_pos;
          end else begin
            push_event(EV_MATCH, held_pos - code, held_pos, held_line, 0);
            sent_hit = 1;
            qpos = held_pos + 1; line_cnt = held_line;
          end
          for (k = 0; k < replay.size() && nq.size() < QUEUE_CAP; k++)
            nq.push_back(replay[k]);
          for (k = qi; k < q.size() && nq.size() < QUEUE_CAP; k++)
            nq.push_back(q[k]);
          replay.delete();
          q = nq;
          qi = 0;
          continue;
        end
        nx = transition(cur_node, f);
        if (nodes[nx].code != 0) begin
          if (nodes[nx].code == NEG_CODE && rescan_valid && p == rescan_at) begin
            if (b == NL_BYTE) line_cnt++;
            cur_node = 0;
          end else begin
            hold_match(nx, p, b);
          end
        end else begin
          if (b == NL_BYTE) line_cnt++;
          cur_node = nx;
          if (f == DOT_CHAR) begin
            push_event(EV_SENT, 0, p, line_cnt, sent_hit);
            sent_hit = 0;
            cur_node = 0;
          end
        end
        qi++;
      end
    endfunction

    function void note_item(scan_item_t it);
      run.delete();
      if (it.op == OP_WRITE) begin
        nodes[it.idx] = it.nd;
        push_event(EV_ACK, 0, 0, 0, 0);
      end else begin
        scan_text(it.text);
      end
      if (run.size() > 0) run[run.size() - 1].last = 1;
      foreach (run[i]) pending.push_back(run[i]);
    endfunction

    function void check_result(msm_result_t got);
      msm_result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item kind=%0d", got.kind);
        return;
      end
      want = pending.pop_front();
      if (got.kind !== want.kind || got.m_start !== want.m_start ||
          got.m_end !== want.m_end || got.line !== want.line ||
          got.had !== want.had || got.last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp k=%0d s=%0d e=%0d l=%0d h=%0d t=%0d got k=%0d s=%0d e=%0d l=%0d h=%0d t=%0d",
                   want.kind, want.m_start, want.m_end, want.line, want.had, want.last,
                   got.kind, got.m_start, got.m_end, got.line, got.had, got.last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  msm_in_if  in_if ();
  msm_out_if out_if ();

  multi_phrase_sentence_matcher_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  match_scoreboard sb = new();
  scan_item_t      items [$];
  int              cycles = 0;
  bit              hold_req = 0;
  bit              sender_done = 0;

  function automatic logic [12:0] pick_link();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 13'(TOP_NODE);
    return 13'($urandom_range(0, POOL - 1));
  endfunction

  function automatic logic [6:0] pick_char();
    case ($urandom_range(0, 7))
      0, 1: return 7'h61;
      2, 3: return 7'h62;
      4:    return DOT_CHAR;
      5:    return SP_CHAR;
      6:    return 7'h31;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic scan_item_t make_node(int idx);
    scan_item_t it;
    int r;
    it.op = OP_WRITE; it.idx = 13'(idx); it.text = 8'($urandom_range(0, 255));
    it.nd.ch = pick_char();
    r = $urandom_range(0, 9);
    if (r < 6) it.nd.code = 0;
    else if (r < 8) it.nd.code = 8'($urandom_range(1, 3));
    else if (r == 8) it.nd.code = NEG_CODE;
    else it.nd.code = 8'($urandom_range(4, 254));
    it.nd.child = pick_link();
    if (idx == TOP_NODE || $urandom_range(0, 1) == 0) it.nd.sib = 0;
    else if (idx >= POOL - 1 || $urandom_range(0, 7) == 0) it.nd.sib = 13'(TOP_NODE);
    else it.nd.sib = 13'($urandom_range(idx + 1, POOL - 1));
    if (idx == 0) it.nd.fail = pick_link();
    else if (idx == TOP_NODE) it.nd.fail = 13'($urandom_range(0, POOL - 1));
    else it.nd.fail = 13'($urandom_range(0, idx - 1));
    return it;
  endfunction

  function automatic scan_item_t make_text(logic [7:0] b);
    scan_item_t it;
    it = make_node(1);
    it.op = OP_SCAN;
    it.text = b;
    return it;
  endfunction

  function automatic logic [7:0] pick_text();
    case ($urandom_range(0, 11))
      0, 1: return 8'h61;
      2:    return 8'h41;
      3, 4: return 8'h62;
      5:    return 8'h42;
      6:    return 8'h2E;
      7:    return 8'h21;
      8:    return NL_BYTE;
      9:    return 8'h20;
      10:   return 8'h31;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_item(scan_item_t it);
    in_if.valid        <= 1'b1;
    in_if.operation    <= it.op;
    in_if.node_index   <= it.idx;
    in_if.node_char    <= it.nd.ch;
    in_if.node_output  <= it.nd.code;
    in_if.node_child   <= it.nd.child;
    in_if.node_sibling <= it.nd.sib;
    in_if.node_failure <= it.nd.fail;
    in_if.text_byte    <= it.text;
    do @(posedge clk); while (!in_if.ready);
  endtask

  initial begin
    logic [7:0] dir_bytes [$];
    int n, burst, gap;
    in_if.valid <= 1'b0; in_if.operation <= OP_SCAN; in_if.node_index <= '0;
    in_if.node_char <= '0; in_if.node_output <= '0; in_if.node_child <= '0;
    in_if.node_sibling <= '0; in_if.node_failure <= '0; in_if.text_byte <= '0;
    for (n = 0; n < POOL; n++) items.push_back(make_node(n));
    items.push_back(make_node(TOP_NODE));
    dir_bytes = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h0A, 8'h2E, 8'h21, 8'h3F, 8'h41,
                  8'h5A, 8'h61, 8'h7A, 8'h30, 8'h39, 8'h20, 8'h61, 8'h62, 8'h61,
                  8'h2E, 8'h62, 8'h62, 8'h0A, 8'h61, 8'h2E};
    foreach (dir_bytes[i]) items.push_back(make_text(dir_bytes[i]));
    for (n = 0; n < 125; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 7) == 0) items.push_back(make_node(TOP_NODE));
        else items.push_back(make_node($urandom_range(0, POOL - 1)));
      end else begin
        items.push_back(make_text(pick_text()));
      end
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    n = 0;
    while (n < items.size()) begin
      burst = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
      while (burst > 0 && n < items.size()) begin
        if (n == 90) begin
          in_if.valid <= 1'b0;
          @(posedge clk);
          while (sb.pending.size() != 0) @(posedge clk);
        end
        if (n == 130) hold_req = 1;
        send_item(items[n]);
        n++;
        burst--;
      end
      gap = $urandom_range(0, 5);
      if (gap > 0 && n < items.size()) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    sender_done = 1;
  end

  initial begin
    int hold_left, mode;
    bit hold_used;
    hold_left = 0; hold_used = 0; mode = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (cycles % 64 == 0) mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (hold_req && !hold_used) begin
        hold_used = 1;
        hold_left = HOLD_LEN;
        out_if.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= 1'($urandom_range(0, 1));
          2: out_if.ready <= (cycles % 5 != 0);
          default: out_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    scan_item_t  it;
    msm_result_t got;
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        it.op = in_if.operation; it.idx = in_if.node_index;
        it.nd.ch = in_if.node_char; it.nd.code = in_if.node_output;
        it.nd.child = in_if.node_child; it.nd.sib = in_if.node_sibling;
        it.nd.fail = in_if.node_failure; it.text = in_if.text_byte;
        sb.note_item(it);
      end
      if (out_if.valid && out_if.ready) begin
        got.kind = out_if.event_kind; got.m_start = out_if.match_start;
        got.m_end = out_if.match_end; got.line = out_if.line_number;
        got.had = out_if.sentence_had_match; got.last = out_if.last_of_run;
        sb.check_result(got);
      end
    end
    if (cycles > CYCLE_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    wait (sender_done);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
